// File: rtl/qr_function_pattern_classifier_core_defines.svh
// Assertion macros for the QR function pattern classifier.
// Used by the top level only; no other dependencies.
`ifndef QR_FUNCTION_PATTERN_CLASSIFIER_CORE_DEFINES_SVH
`define QR_FUNCTION_PATTERN_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define QRFP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qrfp: same-cycle check failed");

// next-cycle implication, disabled in reset
`define QRFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qrfp: next-cycle check failed");

`endif

// File: rtl/qrfp_pkg.sv
// Shared types and constants of the QR function pattern classifier.
// No dependencies.
package qrfp_pkg;

   localparam int MAX_CENTERS = 7;
   localparam int COORD_W     = 8;
   localparam int VERSION_W   = 6;
   localparam int CENTERS_W   = MAX_CENTERS * COORD_W;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;
   localparam int KIND_W      = 3;

   localparam logic [VERSION_W-1:0] VERSION_MIN = 6'd1;
   localparam logic [VERSION_W-1:0] VERSION_MAX = 6'd40;

   // register select: paddr bit 3 picks the 8-byte slot
   localparam logic CSR_SEL_VERSION = 1'b0;
   localparam logic CSR_SEL_CENTERS = 1'b1;

   localparam logic [KIND_W-1:0] REGION_NONE      = 3'd0;
   localparam logic [KIND_W-1:0] REGION_FINDER    = 3'd1;
   localparam logic [KIND_W-1:0] REGION_SEPARATOR = 3'd2;
   localparam logic [KIND_W-1:0] REGION_TIMING    = 3'd3;
   localparam logic [KIND_W-1:0] REGION_ALIGNMENT = 3'd4;

   typedef struct packed {
      logic              is_function_module;
      logic              module_dark;
      logic [KIND_W-1:0] region_kind;
      logic              outside_symbol;
   } result_type;

endpackage

// File: rtl/qrfp_req_if.sv
// Request channel: one module coordinate per beat.
// Depends on qrfp_pkg.
interface qrfp_req_if;
   import qrfp_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] module_row;
   logic [COORD_W-1:0] module_col;

   modport source (output valid, output module_row, output module_col, input ready);
   modport sink   (input valid, input module_row, input module_col, output ready);
endinterface

// File: rtl/qrfp_rsp_if.sv
// Response channel: one classification result per beat.
// Depends on qrfp_pkg.
interface qrfp_rsp_if;
   import qrfp_pkg::*;

   logic              valid;
   logic              ready;
   logic              is_function_module;
   logic              module_dark;
   logic [KIND_W-1:0] region_kind;
   logic              outside_symbol;

   modport source (output valid, output is_function_module, output module_dark,
                   output region_kind, output outside_symbol, input ready);
   modport sink   (input valid, input is_function_module, input module_dark,
                   input region_kind, input outside_symbol, output ready);
endinterface

// File: rtl/qrfp_classify.sv
// Combinational classifier of one module coordinate against the function patterns.
// Depends on qrfp_pkg.
module qrfp_classify (
   input  logic [qrfp_pkg::COORD_W-1:0]   row,
   input  logic [qrfp_pkg::COORD_W-1:0]   col,
   input  logic [qrfp_pkg::VERSION_W-1:0] version,
   input  logic [qrfp_pkg::CENTERS_W-1:0] centers,
   output qrfp_pkg::result_type           result
);
   import qrfp_pkg::*;

   logic [VERSION_W-1:0] ver_eff;
   logic [COORD_W-1:0]   side;
   logic [COORD_W-1:0]   side_m7, side_m8, side_m10;

   logic                 outside;
   logic                 in_tl, in_tr, in_bl, in_finder;
   logic [COORD_W-1:0]   loc_r, loc_c;
   logic [2:0]           fin_dr, fin_dc, fin_d;
   logic                 in_sep;

   logic [COORD_W-1:0]   ctr     [MAX_CENTERS];
   logic                 ctr_ok  [MAX_CENTERS];
   logic                 ctr_lo  [MAX_CENTERS];
   logic                 ctr_hi  [MAX_CENTERS];
   logic [COORD_W-1:0]   rd_full [MAX_CENTERS];
   logic [COORD_W-1:0]   cd_full [MAX_CENTERS];
   logic                 r_near  [MAX_CENTERS];
   logic                 c_near  [MAX_CENTERS];

   logic [MAX_CENTERS-1:0] row_hit;
   logic [MAX_CENTERS-1:0] row_dark;
   logic                   pair_hit;
   logic                   pair_d1;
   logic                   aln_hit, aln_dark;

   logic                 tim_row, tim_col;

   function automatic logic [2:0] dist3(input logic [2:0] x);
      dist3 = (x >= 3'd3) ? (x - 3'd3) : (3'd3 - x);
   endfunction

   // side length and edge offsets
   always_comb begin
      if (version < VERSION_MIN) begin
         ver_eff = VERSION_MIN;
      end else if (version > VERSION_MAX) begin
         ver_eff = VERSION_MAX;
      end else begin
         ver_eff = version;
      end
      side     = 8'd17 + {ver_eff, 2'b00};
      side_m7  = side - 8'd7;
      side_m8  = side - 8'd8;
      side_m10 = side - 8'd10;
   end

   // finders and separators
   always_comb begin
      outside   = (row >= side) || (col >= side);
      in_tl     = (row < 8'd7) && (col < 8'd7);
      in_bl     = (row >= side_m7) && (col < 8'd7);
      in_tr     = (row < 8'd7) && (col >= side_m7);
      in_finder = in_tl || in_bl || in_tr;
      loc_r     = in_bl ? (row - side_m7) : row;
      loc_c     = in_tr ? (col - side_m7) : col;
      fin_dr    = dist3(loc_r[2:0]);
      fin_dc    = dist3(loc_c[2:0]);
      fin_d     = (fin_dr > fin_dc) ? fin_dr : fin_dc;
      in_sep    = ((row < 8'd8) && (col == 8'd7)) || ((row == 8'd7) && (col < 8'd8)) ||
                  ((row < 8'd8) && (col == side_m8)) || ((row == 8'd7) && (col >= side_m8)) ||
                  ((row >= side_m8) && (col == 8'd7)) || ((row == side_m8) && (col < 8'd8));
   end

   // per-center distances and finder-zone flags
   always_comb begin
      for (int k = 0; k < MAX_CENTERS; k++) begin
         ctr[k]     = centers[k*COORD_W +: COORD_W];
         ctr_ok[k]  = ctr[k] >= 8'd3;
         ctr_lo[k]  = ctr[k] < 8'd10;       // ring corner below 8
         ctr_hi[k]  = ctr[k] >= side_m10;   // ring corner at or past side-12
         rd_full[k] = (row >= ctr[k]) ? (row - ctr[k]) : (ctr[k] - row);
         cd_full[k] = (col >= ctr[k]) ? (col - ctr[k]) : (ctr[k] - col);
         r_near[k]  = rd_full[k] <= 8'd2;
         c_near[k]  = cd_full[k] <= 8'd2;
      end
   end

   // first matching column center per row center; the color comes from that pair
   always_comb begin
      for (int a = 0; a < MAX_CENTERS; a++) begin
         row_hit[a]  = 1'b0;
         row_dark[a] = 1'b0;
         for (int b = MAX_CENTERS - 1; b >= 0; b--) begin
            pair_hit = ctr_ok[a] && ctr_ok[b] && r_near[a] && c_near[b] &&
                       !((ctr_lo[a] && ctr_lo[b]) || (ctr_lo[a] && ctr_hi[b]) ||
                         (ctr_hi[a] && ctr_lo[b]));
            pair_d1  = (rd_full[a] <= 8'd1) && (cd_full[b] <= 8'd1) &&
                       ((rd_full[a] != 8'd0) || (cd_full[b] != 8'd0));
            if (pair_hit) begin
               row_hit[a]  = 1'b1;
               row_dark[a] = !pair_d1;
            end
         end
      end
      aln_hit  = 1'b0;
      aln_dark = 1'b0;
      for (int a = MAX_CENTERS - 1; a >= 0; a--) begin
         if (row_hit[a]) begin
            aln_hit  = 1'b1;
            aln_dark = row_dark[a];
         end
      end
   end

   // timing lines and final priority
   always_comb begin
      tim_row = (row == 8'd6) && (col >= 8'd8) && (col < side_m8);
      tim_col = (col == 8'd6) && (row >= 8'd8) && (row < side_m8);

      result = '0;
      if (outside) begin
         result.outside_symbol = 1'b1;
      end else if (in_finder) begin
         result.region_kind = REGION_FINDER;
         result.module_dark = (fin_d != 3'd2);
      end else if (in_sep) begin
         result.region_kind = REGION_SEPARATOR;
      end else if (aln_hit) begin
         result.region_kind = REGION_ALIGNMENT;
         result.module_dark = aln_dark;
      end else if (tim_row) begin
         result.region_kind = REGION_TIMING;
         result.module_dark = !col[0];
      end else if (tim_col) begin
         result.region_kind = REGION_TIMING;
         result.module_dark = !row[0];
      end
      result.is_function_module = (result.region_kind != REGION_NONE);
   end

endmodule

// File: rtl/qr_function_pattern_classifier_core.sv
// Top level of the QR function pattern classifier: CSR port, two-stage pipeline.
// Depends on qrfp_pkg, qrfp_req_if, qrfp_rsp_if, qrfp_classify and the defines header.
//
// Usage
//   req  : one module coordinate (module_row, module_col) per beat, valid/ready.
//   rsp  : one result per request beat, in order: is_function_module,
//          module_dark, region_kind, outside_symbol.
//   csr  : APB-style, 64-bit data, always ready. 0x0 symbol_version (6 bits),
//          0x8 alignment_centers (seven 8-bit centers, zero = unused).
//          Write only while the pipe is empty.
// Path: a request accepted on req is held in the input register, classified
//   combinationally from there, and captured in the result register that
//   drives rsp.
// Throughput: one beat per cycle while rsp.ready stays high; each stage advances when it is free.
// Stall: when rsp.ready is low the result register holds, the input register
//   fills behind it, and req.ready then drops; nothing is dropped or repeated.
// Reset: synchronous, active high; empties both stages, version back to 1 and
//   all alignment centers cleared.
`include "qr_function_pattern_classifier_core_defines.svh"

module qr_function_pattern_classifier_core (
   input  logic                            clock,
   input  logic                            reset,
   qrfp_req_if.sink                        req,
   qrfp_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [qrfp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [qrfp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [qrfp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import qrfp_pkg::*;

   // configuration registers
   logic [VERSION_W-1:0] version_ff, version_in;
   logic [CENTERS_W-1:0] centers_ff, centers_in;
   logic                 csr_wr;

   // stage 1: input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [COORD_W-1:0]   s1_row_ff, s1_row_in;
   logic [COORD_W-1:0]   s1_col_ff, s1_col_in;

   // stage 2: result register
   logic                 s2_valid_ff, s2_valid_in;
   result_type           s2_result_ff, s2_result_in;
   result_type           cls_result;

   logic                 s2_free;
   logic                 s1_free;

   // ---------------- CSR ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      version_in = version_ff;
      centers_in = centers_ff;
      if (csr_wr) begin
         case (csr_paddr[3])
            CSR_SEL_VERSION: version_in = csr_pwdata[VERSION_W-1:0];
            CSR_SEL_CENTERS: centers_in = csr_pwdata[CENTERS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         CSR_SEL_VERSION: csr_prdata = {{(CSR_DATA_W-VERSION_W){1'b0}}, version_ff};
         CSR_SEL_CENTERS: csr_prdata = {{(CSR_DATA_W-CENTERS_W){1'b0}}, centers_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // result register frees when empty or taken; input register frees when
   // empty or moving down into a freed result register
   assign s2_free   = !s2_valid_ff || rsp.ready;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req.ready = s1_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_row_in   = s1_row_ff;
      s1_col_in   = s1_col_ff;
      if (s1_free) begin
         s1_valid_in = req.valid;
         s1_row_in   = req.module_row;
         s1_col_in   = req.module_col;
      end
   end

   always_comb begin
      s2_valid_in  = s2_valid_ff;
      s2_result_in = s2_result_ff;
      if (s2_free) begin
         s2_valid_in  = s1_valid_ff;
         s2_result_in = cls_result;
      end
   end

   qrfp_classify u_classify (
      .row     (s1_row_ff),
      .col     (s1_col_ff),
      .version (version_ff),
      .centers (centers_ff),
      .result  (cls_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff  <= VERSION_MIN;
         centers_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         version_ff  <= version_in;
         centers_ff  <= centers_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_row_ff    <= s1_row_in;
      s1_col_ff    <= s1_col_in;
      s2_result_ff <= s2_result_in;
   end

   // ---------------- response ----------------
   assign rsp.valid              = s2_valid_ff;
   assign rsp.is_function_module = s2_result_ff.is_function_module;
   assign rsp.module_dark        = s2_result_ff.module_dark;
   assign rsp.region_kind        = s2_result_ff.region_kind;
   assign rsp.outside_symbol     = s2_result_ff.outside_symbol;

   // ---------------- assertions ----------------
   `QRFP_ASSERT_NOW(a_outside_clean, clock, reset, rsp.valid && rsp.outside_symbol, !rsp.is_function_module && (rsp.region_kind == REGION_NONE) && !rsp.module_dark)
   `QRFP_ASSERT_NOW(a_func_matches_kind, clock, reset, rsp.valid, rsp.is_function_module == (rsp.region_kind != REGION_NONE))
   `QRFP_ASSERT_NOW(a_dark_is_function, clock, reset, rsp.valid && rsp.module_dark, rsp.is_function_module)
   `QRFP_ASSERT_NEXT(a_s1_holds_on_stall, clock, reset, s1_valid_ff && s2_valid_ff && !rsp.ready, s1_valid_ff && s2_valid_ff)

endmodule

// File: dv/qr_function_pattern_classifier_core_tb.sv
// Self-checking testbench for qr_function_pattern_classifier_core: module coordinates in,
// function-pattern class out, checked against an in-bench classifier of its own.
// Depends on qrfp_pkg, qrfp_req_if, qrfp_rsp_if and the RTL top level.
module qr_function_pattern_classifier_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qrfp_pkg::*;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int HOLD_CYCLES  = 64;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 6;     // idle margin after the final drain of the two-stage pipeline
   localparam int PHASE_ITEMS  = 80;
   localparam int PHASES       = 14;

   // byte addresses: paddr bit 3 picks the register
   localparam logic [CSR_ADDR_W-1:0] ADDR_VERSION = {CSR_SEL_VERSION, 3'b000};
   localparam logic [CSR_ADDR_W-1:0] ADDR_CENTERS = {CSR_SEL_CENTERS, 3'b000};

   typedef struct {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      result_type         res;
   } classified_coord_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   qrfp_req_if req_bus ();
   qrfp_rsp_if rsp_bus ();

   qr_function_pattern_classifier_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow copy of the symbol setup, updated once both CSR writes of a setup complete.
   logic [VERSION_W-1:0] cfg_version = 6'd1;
   logic [CENTERS_W-1:0] cfg_centers = '0;

   classified_coord_type expected_classes[$];

   int  fail_count      = 0;
   int  item_count      = 0;
   int  results_checked = 0;
   int  setting_count   = 0;
   int  cycle_count     = 0;
   bit  steady_flow     = 1'b0;   // both sides stop idling
   bit  hold_request    = 1'b0;   // asks the receiver for a long hold-off
   int  hold_left       = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Classifier
   // ---------------------------------------------------------------------------

   function automatic int chebyshev(input int dr, input int dc);
      if (dr < 0) dr = -dr;
      if (dc < 0) dc = -dc;
      return (dr > dc) ? dr : dc;
   endfunction

   // side length for the current version; out-of-range versions clamp to 1..40
   function automatic int symbol_side();
      int v;
      v = int'(cfg_version);
      if (v < 1) v = 1;
      if (v > 40) v = 40;
      return 17 + 4 * v;
   endfunction

   function automatic int center_of(input int k);
      return int'(cfg_centers[COORD_W*k +: COORD_W]);
   endfunction

   function automatic result_type classify_module(input logic [COORD_W-1:0] row,
                                                  input logic [COORD_W-1:0] col);
      int s, r, c, fr, fc, d, cr, cc, t, l, a, b;
      logic [KIND_W-1:0] kind;
      logic dark;
      result_type res;
      s    = symbol_side();
      r    = int'(row);
      c    = int'(col);
      res  = '0;
      kind = REGION_NONE;
      dark = 1'b0;
      if (r >= s || c >= s) begin
         res.outside_symbol = 1'b1;
         return res;
      end
      // finder zones: top-left, bottom-left, top-right
      fr = -1;
      fc = -1;
      if (r < 7 && c < 7) begin
         fr = 0;
         fc = 0;
      end else if (r >= s - 7 && c < 7) begin
         fr = s - 7;
         fc = 0;
      end else if (r < 7 && c >= s - 7) begin
         fr = 0;
         fc = s - 7;
      end
      if (fr >= 0) begin
         d    = chebyshev(r - fr - 3, c - fc - 3);
         kind = REGION_FINDER;
         dark = (d == 3 || d <= 1);
      end else if ((r < 8 && c == 7) || (r == 7 && c < 8) ||
                   (r < 8 && c == s - 8) || (r == 7 && c >= s - 8) ||
                   (r >= s - 8 && c == 7) || (r == s - 8 && c < 8)) begin
         kind = REGION_SEPARATOR;
      end else begin
         // every (row center, col center) pair; rings touching a finder zone skipped
         for (a = 0; a < MAX_CENTERS && kind == REGION_NONE; a++) begin
            cr = center_of(a);
            if (cr < 3) continue;
            for (b = 0; b < MAX_CENTERS; b++) begin
               cc = center_of(b);
               if (cc < 3) continue;
               t = cr - 2;
               l = cc - 2;
               if ((t < 8 && l < 8) || (t < 8 && l >= s - 12) || (t >= s - 12 && l < 8))
                  continue;
               d = chebyshev(r - cr, c - cc);
               if (d <= 2) begin
                  kind = REGION_ALIGNMENT;
                  dark = (d != 1);
                  break;
               end
            end
         end
         // timing only where no ring landed
         if (kind == REGION_NONE) begin
            if (r == 6 && c >= 8 && c < s - 8) begin
               kind = REGION_TIMING;
               dark = ~col[0];
            end else if (c == 6 && r >= 8 && r < s - 8) begin
               kind = REGION_TIMING;
               dark = ~row[0];
            end
         end
      end
      res.is_function_module = (kind != REGION_NONE);
      res.module_dark        = dark;
      res.region_kind        = kind;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // evenly spread center list in the style of the standard tables
   function automatic logic [CENTERS_W-1:0] spaced_centers(input int v);
      int n, last, step, k;
      logic [CENTERS_W-1:0] list_bits;
      if (v < 1) v = 1;
      if (v > 40) v = 40;
      n    = v / 7 + 2;
      last = 17 + 4 * v - 7;
      step = (last - 6 + n - 2) / (n - 1);
      if (step % 2 != 0) step++;
      list_bits = '0;
      list_bits[COORD_W-1:0] = 8'd6;
      for (k = 1; k < n; k++)
         list_bits[COORD_W*k +: COORD_W] = 8'(last - (n - 1 - k) * step);
      return list_bits;
   endfunction

   // arbitrary bytes, with plenty of unused and near-edge entries
   function automatic logic [CENTERS_W-1:0] scattered_centers();
      int k;
      logic [CENTERS_W-1:0] list_bits;
      for (k = 0; k < MAX_CENTERS; k++) begin
         case ($urandom_range(9))
            0, 1, 2: list_bits[COORD_W*k +: COORD_W] = '0;
            3:       list_bits[COORD_W*k +: COORD_W] = 8'($urandom_range(4, 1));
            default: list_bits[COORD_W*k +: COORD_W] = 8'($urandom_range(255));
         endcase
      end
      return list_bits;
   endfunction

   // one axis of a coordinate, weighted toward the patterns of the current symbol
   function automatic logic [COORD_W-1:0] pick_axis();
      int s, sel;
      s   = symbol_side();
      sel = $urandom_range(99);
      if (sel < 20) return 8'($urandom_range(255));
      if (sel < 55) return 8'($urandom_range(s - 1));
      if (sel < 68) return 8'($urandom_range(8));
      if (sel < 80) return 8'(s - 1 - $urandom_range(8));
      if (sel < 86) return 8'd6;
      return 8'(center_of($urandom_range(MAX_CENTERS - 1)) + $urandom_range(6) - 3);
   endfunction

   // One request beat; valid is left high so the next call can follow back to back.
   task automatic send_coord(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col);
      classified_coord_type entry;
      while (!steady_flow && $urandom_range(99) < 8) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.module_row <= row;
      req_bus.module_col <= col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      entry.row = row;
      entry.col = col;
      entry.res = classify_module(row, col);
      expected_classes.push_back(entry);
      item_count++;
   endtask

   task automatic send_points(input int pts[$]);
      int i;
      for (i = 0; i + 1 < pts.size(); i += 2)
         send_coord(8'(pts[i]), 8'(pts[i + 1]));
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_classes.size() != 0);
   endtask

   // setup and access phase; psel stays up so writes can chain
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   // new symbol setup, only with the pipe empty
   task automatic program_symbol(input logic [VERSION_W-1:0] version,
                                 input logic [CENTERS_W-1:0] centers);
      wait_for_drain();
      write_csr(ADDR_VERSION, CSR_DATA_W'(version));
      write_csr(ADDR_CENTERS, CSR_DATA_W'(centers));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_version = version;
      cfg_centers = centers;
      setting_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Version 1 and no centers straight out of reset: finders, separators, timing, edges.
   task automatic test_reset_defaults();
      int pts[$];
      pts = '{0, 0,  3, 3,  1, 1,  2, 4,  6, 6,  7, 7,  7, 0,  0, 7,
              13, 0, 13, 7, 14, 3, 20, 0, 0, 20, 0, 13, 7, 14, 6, 8,
              6, 9,  8, 6,  9, 6,  10, 10, 20, 20, 21, 0, 0, 21,
              255, 255, 255, 0, 0, 255, 170, 85, 85, 170};
      send_points(pts);
   endtask

   // Version 0 clamps up, 41 and 63 clamp down; probe around the far edges.
   task automatic test_version_extremes();
      int pts[$];
      program_symbol(6'd0, '0);
      pts = '{20, 20, 21, 0, 0, 21, 14, 7, 13, 0, 13, 12, 6, 12, 12, 6};
      send_points(pts);
      program_symbol(6'd41, '0);
      pts = '{176, 176, 177, 0, 0, 177, 170, 0, 0, 176, 6, 168, 168, 6,
              169, 7, 7, 169, 6, 169};
      send_points(pts);
      program_symbol(6'd63, '0);
      pts = '{176, 0, 0, 176, 176, 177, 173, 3};
      send_points(pts);
      program_symbol(VERSION_MAX, '1);
      pts = '{255, 255, 253, 253, 100, 100};
      send_points(pts);
   endtask

   // Alignment rings: over timing, excluded by finders, unused entries, past the edge.
   task automatic test_alignment_rings();
      int pts[$];
      // version 7, centers 6/22/38
      program_symbol(6'd7, 56'h00_00_00_00_26_16_06);
      pts = '{22, 22, 21, 22, 20, 20, 24, 23, 6, 22, 6, 20, 6, 24, 6, 26,
              6, 27, 22, 6, 21, 6, 38, 38, 36, 22, 4, 4, 6, 38, 38, 6};
      send_points(pts);
      // entries 0, 1 and 6 unused; 3 and 20 near the top edge; 44 and 255 reach past it
      program_symbol(6'd7, 56'h00_14_2C_FF_03_02_01);
      pts = '{3, 20, 1, 18, 5, 22, 20, 3, 20, 1, 44, 44, 43, 43, 42, 42,
              44, 20, 20, 44, 3, 44, 2, 2, 1, 1, 0, 44, 44, 0};
      send_points(pts);
   endtask

   // Long receiver hold-off fills the pipe and stalls req; then a full pause.
   task automatic test_backpressure();
      int n;
      program_symbol(6'd10, spaced_centers(10));
      hold_request = 1'b1;
      for (n = 0; n < 48; n++) send_coord(pick_axis(), pick_axis());
      wait_for_drain();
      for (n = 0; n < 24; n++) send_coord(pick_axis(), pick_axis());
   endtask

   // Many symbol setups with mostly in-symbol coordinates near the patterns.
   task automatic test_random_symbols();
      int phase, n, v;
      logic [CENTERS_W-1:0] list_bits;
      for (phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(9))
            0:       v = 0;
            1:       v = 63;
            2:       v = 41;
            3:       v = 1;
            4:       v = 40;
            default: v = $urandom_range(40, 1);
         endcase
         if ($urandom_range(9) < 7) list_bits = spaced_centers(v);
         else list_bits = scattered_centers();
         program_symbol(6'(v), list_bits);
         steady_flow = (phase == 5);   // one phase runs without any idling
         for (n = 0; n < PHASE_ITEMS; n++) send_coord(pick_axis(), pick_axis());
      end
      wait_for_drain();
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver, checker, watchdog
   // ---------------------------------------------------------------------------

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (steady_flow) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 8);
         end
      end
   end

   task automatic report_mismatch(input string field, input classified_coord_type entry,
                                  input int exp_val, input logic [KIND_W-1:0] act_val);
      $display("%0t: (%0d,%0d) %s expected %0d, got %0d", $time, entry.row, entry.col,
               field, exp_val, act_val);
      fail_count++;
   endtask

   initial begin
      classified_coord_type entry;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_classes.size() == 0) begin
               $display("%0t: result beat with nothing outstanding", $time);
               fail_count++;
            end else begin
               entry = expected_classes.pop_front();
               results_checked++;
               if (rsp_bus.is_function_module !== entry.res.is_function_module)
                  report_mismatch("is_function_module", entry,
                                  entry.res.is_function_module, rsp_bus.is_function_module);
               if (rsp_bus.module_dark !== entry.res.module_dark)
                  report_mismatch("module_dark", entry,
                                  entry.res.module_dark, rsp_bus.module_dark);
               if (rsp_bus.region_kind !== entry.res.region_kind)
                  report_mismatch("region_kind", entry,
                                  entry.res.region_kind, rsp_bus.region_kind);
               if (rsp_bus.outside_symbol !== entry.res.outside_symbol)
                  report_mismatch("outside_symbol", entry,
                                  entry.res.outside_symbol, rsp_bus.outside_symbol);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, expected_classes.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.module_row <= '0;
      req_bus.module_col <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_version_extremes();
      test_alignment_rings();
      test_backpressure();
      test_random_symbols();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d coordinates under %0d symbol setups, %0d results checked;",
               item_count, setting_count, results_checked);
      $display("versions 0..63, standard and scattered alignment lists, stalls and hold-offs.");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/qrfp_pkg.sv
rtl/qrfp_req_if.sv
rtl/qrfp_rsp_if.sv
rtl/qrfp_classify.sv
rtl/qr_function_pattern_classifier_core.sv
dv/qr_function_pattern_classifier_core_tb.sv
